// ===== rtl/u8l1_pkg.sv =====
// u8l1_pkg: types and constants shared by the UTF-8 to Latin-1 byte recovery block.
// No dependencies; used by every module under rtl.

package u8l1_pkg;

    // Verdict codes carried on the result item that closes a string
    typedef enum logic [1:0] {
        VERDICT_RECOVERABLE = 2'd0,
        VERDICT_ASCII       = 2'd1,
        VERDICT_NOT_LATIN1  = 2'd2
    } u8l1_verdict_t;

    // Continuation bytes still expected
    typedef enum logic [1:0] {
        PEND_LEAD  = 2'd0,
        PEND_ONE   = 2'd1,
        PEND_TWO   = 2'd2
    } u8l1_pend_t;

    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD2_BITS  = 8'h1F;
    localparam logic [7:0] LEAD3_BITS  = 8'h0F;
    localparam logic [7:0] CONT_BITS   = 8'h3F;
    localparam logic [7:0] HIGH_FIRST  = 8'h80;

    // One input item as held in the input register
    typedef struct packed {
        logic       is_last;
        logic [7:0] in_byte;
    } u8l1_item_t;

    // One result item as held in the result register
    typedef struct packed {
        u8l1_verdict_t verdict;
        logic          string_done;
        logic          byte_valid;
        logic [7:0]    latin1_byte;
    } u8l1_result_t;

endpackage

// ===== rtl/u8l1_in_stage.sv =====
// u8l1_in_stage: input register of the byte recovery block.
// Depends on u8l1_pkg for the item type.

module u8l1_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             take,
    output logic             item_valid,
    output u8l1_pkg::u8l1_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    u8l1_pkg::u8l1_item_t item_reg;
    logic                 accept;

    // Free when empty or when the held item moves on this cycle
    assign s_tready   = !valid_reg || take;
    assign accept     = s_tvalid && s_tready;
    assign valid_next = accept ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.in_byte <= s_tdata;
            item_reg.is_last <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/u8l1_decode.sv =====
// u8l1_decode: decode state, per-byte decode logic and result register.
// Depends on u8l1_pkg for types, codes and byte masks.

module u8l1_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  u8l1_pkg::u8l1_item_t item,
    output logic                 take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output u8l1_pkg::u8l1_result_t result
);

    u8l1_pkg::u8l1_pend_t   pend_reg, pend_next;
    logic [15:0]            point_reg, point_next;
    logic                   seen_reg, seen_next;
    logic                   failed_reg, failed_next;
    logic                   out_valid_reg, out_valid_next;
    u8l1_pkg::u8l1_result_t result_reg;
    u8l1_pkg::u8l1_result_t result_next;

    logic [7:0]  b;
    logic        last;
    logic        complete;
    logic [15:0] cp;
    logic        emit;
    logic        load;
    logic        fail_step;
    logic [15:0] cont_bits;

    assign b    = item.in_byte;
    assign last = item.is_last;

    // Advance whenever the result register is empty or being emptied
    assign take = item_valid && (!out_valid_reg || m_tready);

    always_comb begin
        pend_next  = pend_reg;
        point_next = point_reg;
        complete   = 1'b0;
        fail_step  = 1'b0;
        cp         = 16'd0;
        cont_bits  = {10'd0, b[5:0] & u8l1_pkg::CONT_BITS[5:0]};
        if (pend_reg == u8l1_pkg::PEND_LEAD) begin
            if (b < u8l1_pkg::HIGH_FIRST) begin
                cp       = {8'd0, b};
                complete = 1'b1;
            end else if ((b & u8l1_pkg::LEAD2_MASK) == u8l1_pkg::LEAD2_CODE) begin
                point_next = {5'd0, b[4:0] & u8l1_pkg::LEAD2_BITS[4:0], 6'd0};
                pend_next  = u8l1_pkg::PEND_ONE;
            end else if ((b & u8l1_pkg::LEAD3_MASK) == u8l1_pkg::LEAD3_CODE) begin
                point_next = {b[3:0] & u8l1_pkg::LEAD3_BITS[3:0], 12'd0};
                pend_next  = u8l1_pkg::PEND_TWO;
            end else begin
                fail_step = 1'b1;
            end
        end else if (pend_reg == u8l1_pkg::PEND_TWO) begin
            point_next = point_reg | (cont_bits << 6);
            pend_next  = u8l1_pkg::PEND_ONE;
        end else begin
            // Final continuation: code point complete
            cp         = point_reg | cont_bits;
            point_next = 16'd0;
            pend_next  = u8l1_pkg::PEND_LEAD;
            complete   = 1'b1;
        end
    end

    always_comb begin
        emit        = 1'b0;
        seen_next   = seen_reg;
        failed_next = failed_reg;
        if (!failed_reg) begin
            if (fail_step) begin
                failed_next = 1'b1;
            end
            if (complete) begin
                if (cp[15:8] != 8'd0) begin
                    failed_next = 1'b1;
                end else begin
                    emit = 1'b1;
                    if (cp[7]) begin
                        seen_next = 1'b1;
                    end
                end
            end
            if (last && pend_next != u8l1_pkg::PEND_LEAD) begin
                failed_next = 1'b1;
            end
        end
    end

    always_comb begin
        result_next.latin1_byte = emit ? cp[7:0] : 8'd0;
        result_next.byte_valid  = emit;
        result_next.string_done = last;
        if (!last) begin
            result_next.verdict = u8l1_pkg::VERDICT_RECOVERABLE;
        end else if (failed_next) begin
            result_next.verdict = u8l1_pkg::VERDICT_NOT_LATIN1;
        end else if (seen_next) begin
            result_next.verdict = u8l1_pkg::VERDICT_RECOVERABLE;
        end else begin
            result_next.verdict = u8l1_pkg::VERDICT_ASCII;
        end
    end

    assign load           = take && (emit || last);
    assign out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= u8l1_pkg::PEND_LEAD;
            point_reg     <= 16'd0;
            seen_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                if (last) begin
                    // Close the string: back to the start state
                    pend_reg   <= u8l1_pkg::PEND_LEAD;
                    point_reg  <= 16'd0;
                    seen_reg   <= 1'b0;
                    failed_reg <= 1'b0;
                end else if (!failed_reg) begin
                    pend_reg   <= pend_next;
                    point_reg  <= point_next;
                    seen_reg   <= seen_next;
                    failed_reg <= failed_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && last) |=> (pend_reg == u8l1_pkg::PEND_LEAD && !failed_reg && !seen_reg))
        else $error("state not cleared after last byte");

    a_no_emit_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && failed_reg) |-> !emit)
        else $error("byte emitted after failure");

    a_result_has_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !result_reg.byte_valid) |-> result_reg.string_done)
        else $error("result with neither byte nor end of string");

    a_verdict_at_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !result_reg.string_done)
            |-> (result_reg.verdict == u8l1_pkg::VERDICT_RECOVERABLE))
        else $error("verdict set on a mid-string result");

    a_empty_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !result_reg.byte_valid) |-> (result_reg.latin1_byte == 8'd0))
        else $error("data byte set without byte_valid");

endmodule

// ===== rtl/utf8_latin1_byte_recovery.sv =====
// UTF-8 to Latin-1 byte recovery block: top level.
// Takes one UTF-8 byte per item on the s_ channel, returns recovered Latin-1
// bytes and an end-of-string verdict on the m_ channel.
// s_tdata carries the raw byte, s_tlast marks the final byte of a string.
// m_tdata carries the recovered byte; m_tuser holds byte_valid (bit 0) and
// the verdict (bits 2:1); m_tlast marks the item closing a string.
// A byte that completes a code point of 0xFF or less gives an item; so does
// the last byte of a string, which always carries the verdict: recoverable,
// pure ASCII or not Latin-1.  Lead bytes that start nothing, code points above
// 0xFF and strings cut off mid-sequence fail the string; no bytes are sent
// after a failure until the verdict.
// An accepted byte is held in the input register, then decoded into the
// result register and presented on m_.  Throughput: one byte per cycle while
// the receiver keeps up; the decode between the registers is combinational.
// Reset (aresetn low, synchronous) empties both registers and returns the
// decoder to expecting a lead byte.  When the receiver stalls, a full result
// register holds and s_tready drops as soon as the input register holds an
// item.
// Depends on u8l1_pkg, u8l1_in_stage and u8l1_decode.

module utf8_latin1_byte_recovery (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] latin1_byte
    output logic [2:0] m_tuser,   // [0] byte_valid, [2:1] verdict
    output logic       m_tlast    // string_done
);

    logic                   item_valid;
    logic                   take;
    u8l1_pkg::u8l1_item_t   item;
    u8l1_pkg::u8l1_result_t result;

    u8l1_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    u8l1_decode u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    assign m_tdata = result.latin1_byte;
    assign m_tuser = {result.verdict, result.byte_valid};
    assign m_tlast = result.string_done;

endmodule

// ===== bench/utf8_latin1_byte_recovery_tb.sv =====
// Self-checking bench for the UTF-8 to Latin-1 byte recovery block.
// Drives UTF-8 strings byte by byte and checks each recovered byte and verdict.
// Depends on u8l1_pkg and utf8_latin1_byte_recovery under rtl.

module utf8_latin1_byte_recovery_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef logic [7:0] byte_q_t[$];

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    // decoder state as predicted
    u8l1_pkg::u8l1_pend_t cont_left;
    logic [15:0]          point_bits;
    logic                 high_seen;
    logic                 string_failed;

    u8l1_pkg::u8l1_result_t latin1_expected[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int error_count   = 0;
    int bytes_sent    = 0;
    int strings_sent  = 0;
    int results_seen  = 0;
    int ascii_strings = 0;
    int recov_strings = 0;
    int bad_strings   = 0;

    utf8_latin1_byte_recovery dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d items outstanding",
                     cycle_count, latin1_expected.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void clear_decoder();
        cont_left     = u8l1_pkg::PEND_LEAD;
        point_bits    = '0;
        high_seen     = 1'b0;
        string_failed = 1'b0;
    endfunction

    function automatic void log_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t ns  MISMATCH: %s", $realtime, msg);
        end
    endfunction

    // Advance the predicted decoder by one accepted byte and queue any result item.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        u8l1_pkg::u8l1_result_t res;
        logic                   point_done;
        logic                   emit;
        logic [15:0]            point;
        point_done = 1'b0;
        emit       = 1'b0;
        point      = '0;
        if (!string_failed) begin
            if (cont_left == u8l1_pkg::PEND_LEAD) begin
                if (b < u8l1_pkg::HIGH_FIRST) begin
                    point      = {8'h00, b};
                    point_done = 1'b1;
                end else if ((b & u8l1_pkg::LEAD2_MASK) == u8l1_pkg::LEAD2_CODE) begin
                    point_bits = 16'(b & u8l1_pkg::LEAD2_BITS) << 6;
                    cont_left  = u8l1_pkg::PEND_ONE;
                end else if ((b & u8l1_pkg::LEAD3_MASK) == u8l1_pkg::LEAD3_CODE) begin
                    point_bits = 16'(b & u8l1_pkg::LEAD3_BITS) << 12;
                    cont_left  = u8l1_pkg::PEND_TWO;
                end else begin
                    string_failed = 1'b1;
                end
            end else begin
                // top two bits of a continuation byte are never looked at
                if (cont_left == u8l1_pkg::PEND_TWO) begin
                    point_bits = point_bits | (16'(b & u8l1_pkg::CONT_BITS) << 6);
                    cont_left  = u8l1_pkg::PEND_ONE;
                end else begin
                    point      = point_bits | 16'(b & u8l1_pkg::CONT_BITS);
                    point_bits = '0;
                    cont_left  = u8l1_pkg::PEND_LEAD;
                    point_done = 1'b1;
                end
            end
            if (point_done) begin
                if (point > 16'h00FF) begin
                    string_failed = 1'b1;
                end else begin
                    emit = 1'b1;
                    if (point >= 16'(u8l1_pkg::HIGH_FIRST)) high_seen = 1'b1;
                end
            end
            if (last && cont_left != u8l1_pkg::PEND_LEAD) string_failed = 1'b1;
        end
        if (emit || last) begin
            res.latin1_byte = emit ? point[7:0] : 8'h00;
            res.byte_valid  = emit;
            res.string_done = last;
            // the verdict field stays zero on items that do not close a string
            res.verdict     = u8l1_pkg::VERDICT_RECOVERABLE;
            if (last) begin
                if (string_failed) begin
                    res.verdict = u8l1_pkg::VERDICT_NOT_LATIN1;
                    bad_strings++;
                end else if (high_seen) begin
                    recov_strings++;
                end else begin
                    res.verdict = u8l1_pkg::VERDICT_ASCII;
                    ascii_strings++;
                end
            end
            latin1_expected.insert(latin1_expected.size(), res);
        end
        if (last) clear_decoder();
    endfunction

    always @(posedge aclk) begin
        u8l1_pkg::u8l1_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (latin1_expected.size() == 0) begin
                log_error($sformatf("unexpected item tdata=%h tuser=%b tlast=%b",
                                    m_tdata, m_tuser, m_tlast));
            end else begin
                want = latin1_expected.pop_front();
                if (m_tdata !== want.latin1_byte || m_tuser[0] !== want.byte_valid ||
                    m_tuser[2:1] !== want.verdict || m_tlast !== want.string_done) begin
                    log_error($sformatf({"expected byte=%h valid=%b done=%b verdict=%0d, ",
                                         "got byte=%h valid=%b done=%b verdict=%0d"},
                                        want.latin1_byte, want.byte_valid,
                                        want.string_done, want.verdict,
                                        m_tdata, m_tuser[0], m_tlast, m_tuser[2:1]));
                end
            end
        end
    end

    // Hold the byte until accepted; before it, drop valid while a random draw falls under the set idle rate.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        decode_byte(b, last);
    endtask

    task automatic send_string(input byte_q_t str);
        foreach (str[i]) send_byte(str[i], i == str.size() - 1);
        strings_sent++;
    endtask

    task automatic test_ascii_extremes();
        send_string('{8'h00, 8'h7F});
    endtask

    task automatic test_two_byte_points();
        send_string('{8'hC2, 8'h80, 8'hC3, 8'hBF});
        // overlong forms still decode; the continuation's top bits go unchecked
        send_string('{8'hC0, 8'h80, 8'hC1, 8'h3F});
    endtask

    task automatic test_three_byte_points();
        send_string('{8'hE0, 8'h83, 8'hBF});
    endtask

    task automatic test_failures();
        send_string('{8'h80});
        // bytes after a bad lead are swallowed up to the verdict
        send_string('{8'hF0, 8'h41});
        send_string('{8'hC4, 8'h80, 8'hC3, 8'hA9});
        send_string('{8'hE0, 8'h84, 8'h80});
    endtask

    task automatic test_cut_off();
        send_string('{8'hC3});
        send_string('{8'hE0, 8'h82});
    endtask

    // Mostly well-formed strings with random content, some noise and some broken ones.
    task automatic test_random_strings(input int n_bytes);
        byte_q_t    str;
        int         sent;
        int         flavour;
        int         kind;
        int         pos;
        logic [7:0] cp;
        sent = 0;
        while (sent < n_bytes) begin
            str.delete();
            flavour = $urandom_range(99);
            if (flavour < 12) begin
                repeat ($urandom_range(1, 8)) str.insert(str.size(), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    kind = $urandom_range(99);
                    cp   = 8'($urandom);
                    if (kind < 40) begin
                        str.insert(str.size(), {1'b0, cp[6:0]});
                    end else if (kind < 80) begin
                        str.insert(str.size(), {6'b110000, cp[7:6]});
                        str.insert(str.size(), {2'($urandom), cp[5:0]});
                    end else begin
                        str.insert(str.size(), 8'hE0);
                        str.insert(str.size(), {2'($urandom), 4'b0000, cp[7:6]});
                        str.insert(str.size(), {2'($urandom), cp[5:0]});
                    end
                end
                if (flavour >= 88) begin
                    pos = $urandom_range(str.size());
                    case ($urandom_range(3))
                        0: begin
                            str.insert(str.size(), {3'b110, 5'($urandom)});
                        end
                        1: begin
                            str.insert(str.size(), {4'b1110, 4'($urandom)});
                            if ($urandom_range(1)) str.insert(str.size(), 8'($urandom));
                        end
                        2: begin
                            if ($urandom_range(1)) begin
                                str.insert(pos, 8'($urandom));
                                str.insert(pos, {3'b110, 5'($urandom_range(4, 31))});
                            end else begin
                                str.insert(pos, 8'($urandom));
                                str.insert(pos, 8'($urandom));
                                str.insert(pos, {4'b1110, 4'($urandom_range(1, 15))});
                            end
                        end
                        default: begin
                            if ($urandom_range(1)) str.insert(pos, 8'($urandom_range(128, 191)));
                            else                   str.insert(pos, 8'($urandom_range(240, 255)));
                        end
                    endcase
                end
            end
            sent += str.size();
            send_string(str);
        end
    endtask

    initial begin
        clear_decoder();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 56;
        test_ascii_extremes();
        test_two_byte_points();
        test_three_byte_points();
        test_failures();
        test_cut_off();
        test_random_strings(560);

        send_idle_pct = 56;
        recv_idle_pct = 26;
        test_random_strings(560);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strings(560);

        s_tvalid <= 1'b0;
        while (latin1_expected.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Decoded %0d bytes in %0d strings over three stall patterns; %0d items checked.",
                 bytes_sent, strings_sent, results_seen);
        $display("Strings closed as pure ASCII %0d, recoverable %0d, not Latin-1 %0d; %0d mismatches.",
                 ascii_strings, recov_strings, bad_strings, error_count);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
